// ===== hw/rtl/hue_pkg.sv =====
// Package for the HTML/URL byte escaper: beat types, item classes and escape tables.
// No dependencies; used by every module in hw/rtl.
package hue_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_in;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       run_end;
    logic       text_end;
  } out_beat_t;

  localparam logic OP_HTML = 1'b0;
  localparam logic OP_URL  = 1'b1;

  typedef enum logic [2:0] {
    K_PASS = 3'd0,
    K_AMP  = 3'd1,
    K_LT   = 3'd2,
    K_GT   = 3'd3,
    K_QUOT = 3'd4,
    K_HEX  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } item_t;

  function automatic logic url_keeps(input logic [7:0] c);
    logic keep;
    keep = 1'b0;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) begin
      keep = 1'b1;
    end else begin
      unique case (c)
        8'h7E, 8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h2C,
        8'h25, 8'h23, 8'h40, 8'h3F, 8'h3D, 8'h3B, 8'h3A, 8'h2F, 8'h24: keep = 1'b1;
        default: keep = 1'b0;
      endcase
    end
    return keep;
  endfunction

  function automatic kind_t classify(input logic op, input logic [7:0] c);
    kind_t k;
    k = K_PASS;
    if (op == OP_HTML) begin
      unique case (c)
        8'h26:   k = K_AMP;
        8'h3C:   k = K_LT;
        8'h3E:   k = K_GT;
        8'h22:   k = K_QUOT;
        default: k = K_PASS;
      endcase
    end else begin
      priority if (url_keeps(c)) k = K_PASS;
      else if (c == 8'h26)       k = K_AMP;
      else                       k = K_HEX;
    end
    return k;
  endfunction

  function automatic logic [2:0] run_len(input kind_t k);
    logic [2:0] n;
    unique case (k)
      K_PASS:  n = 3'd1;
      K_AMP:   n = 3'd5;
      K_LT:    n = 3'd4;
      K_GT:    n = 3'd4;
      K_QUOT:  n = 3'd6;
      K_HEX:   n = 3'd3;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) d = 8'h30 + {4'h0, n};
    else           d = 8'h37 + {4'h0, n};
    return d;
  endfunction

  // "&amp;" "&lt;" "&gt;" "&quot;"
  function automatic logic [7:0] run_byte(input item_t it, input logic [2:0] idx);
    logic [7:0] b;
    b = it.data;
    unique case (it.kind)
      K_PASS: b = it.data;
      K_AMP: begin
        unique case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h61;
          3'd2:    b = 8'h6D;
          3'd3:    b = 8'h70;
          default: b = 8'h3B;
        endcase
      end
      K_LT, K_GT: begin
        unique case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = (it.kind == K_LT) ? 8'h6C : 8'h67;
          3'd2:    b = 8'h74;
          default: b = 8'h3B;
        endcase
      end
      K_QUOT: begin
        unique case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h71;
          3'd2:    b = 8'h75;
          3'd3:    b = 8'h6F;
          3'd4:    b = 8'h74;
          default: b = 8'h3B;
        endcase
      end
      K_HEX: begin
        unique case (idx)
          3'd0:    b = 8'h25;
          3'd1:    b = hex_digit(it.data[7:4]);
          default: b = hex_digit(it.data[3:0]);
        endcase
      end
      default: b = it.data;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/hue_front.sv =====
// Front stage: accepts input beats and registers them with their escape class.
// Depends on hue_pkg.
module hue_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  hue_pkg::in_beat_t in_data,
  output logic              q_push,
  input  logic              q_full,
  output hue_pkg::item_t    q_item
);

  logic           valid_r, valid_nxt;
  hue_pkg::item_t item_r;
  logic           take;

  assign q_push  = valid_r && !q_full;
  assign in_full = valid_r && q_full;
  assign take    = in_push && !in_full;
  assign q_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take)        valid_nxt = 1'b1;
    else if (q_push) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.kind <= hue_pkg::classify(in_data.operation, in_data.byte_in);
      item_r.data <= in_data.byte_in;
      item_r.last <= in_data.last_byte;
    end
  end

endmodule

// ===== hw/rtl/hue_queue.sv =====
// Short queue of classified items between front and back stages.
// Depends on hue_pkg.
module hue_queue #(
  parameter int DEPTH = hue_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  hue_pkg::item_t wr_item,
  input  logic           pop,
  output logic           empty,
  output hue_pkg::item_t rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hue_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_item;
  end

endmodule

// ===== hw/rtl/hue_back.sv =====
// Back stage: expands head item into its escaped run, one beat per cycle if popped.
// Depends on hue_pkg.
module hue_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  hue_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output hue_pkg::out_beat_t out_data
);

  logic               ovalid_r, ovalid_nxt;
  hue_pkg::out_beat_t obeat_r;
  logic [2:0]         idx_r, idx_nxt;
  logic               load, at_end;

  assign load      = !q_empty && (!ovalid_r || out_pop);
  assign at_end    = (idx_r == hue_pkg::run_len(q_item.kind) - 3'd1);
  assign q_pop     = load && at_end;
  assign out_empty = !ovalid_r;
  assign out_data  = obeat_r;

  always_comb begin
    ovalid_nxt = ovalid_r;
    idx_nxt    = idx_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = at_end ? 3'd0 : idx_r + 3'd1;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      idx_r    <= 3'd0;
    end else begin
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obeat_r.byte_out <= hue_pkg::run_byte(q_item, idx_r);
      obeat_r.run_end  <= at_end;
      obeat_r.text_end <= at_end && q_item.last;
    end
  end

endmodule

// ===== hw/rtl/html_url_byte_escaper.sv =====
// Top level of the HTML/URL byte escaper: front stage, item queue, back stage.
// Depends on hue_pkg, hue_front, hue_queue, hue_back.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_push / in_full    | in_data: operation, byte_in, last_byte
//   out     | out_empty / out_pop  | out_data: byte_out, run_end, text_end
//
// One input beat per cycle enters while the queue has room; the back stage
// emits one output beat per cycle while out_pop takes them, and a byte
// expands to 1 to 6 beats (1 pass-through, 3 percent-hex, 4 to 6 entity).
// The first output beat passes the front register, the queue and the output
// register. Synchronous active-low reset empties all stages. Either side may
// stall independently; the queue of QUEUE_DEPTH items absorbs the difference.
module html_url_byte_escaper #(
  parameter int QUEUE_DEPTH = hue_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  hue_pkg::in_beat_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output hue_pkg::out_beat_t out_data
);

  logic           f_push, q_full, q_empty, q_pop;
  hue_pkg::item_t f_item, q_item;

  hue_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (f_push),
    .q_full  (q_full),
    .q_item  (f_item)
  );

  hue_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .full    (q_full),
    .wr_item (f_item),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  hue_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
